### rtl/pdu_pkg.sv
// Shared types, constants and helpers for the percent decoder.
package pdu_pkg;

  localparam logic [7:0] PERCENT   = 8'h25;
  localparam int         BURST_MAX = 6;
  localparam int         CNT_W     = 3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PCT     = 3'd1,
    PH_PCT_H   = 3'd2,
    PH_PAIR_HI = 3'd3,
    PH_PAIR_P  = 3'd4,
    PH_PAIR_PH = 3'd5
  } phase_t;

  // Up to six output bytes caused by one input item; data[0] goes out first.
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] data;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } burst_t;

  function automatic logic is_hex(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] b);
    logic [3:0] r;
    r = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = 4'(b - 8'h57);
    end
    return r;
  endfunction

  function automatic logic [7:0] pair_value(logic [7:0] hi, logic [7:0] lo);
    return {hex_nibble(hi), hex_nibble(lo)};
  endfunction

  // Append one byte to a burst.
  function automatic burst_t burst_push(burst_t bu, logic [7:0] v);
    burst_t r;
    r = bu;
    if (bu.count < CNT_W'(BURST_MAX)) begin
      r.data[bu.count] = v;
      r.count          = bu.count + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

### rtl/pdu_front.sv
// Front end: takes input items, tracks the escape phase, builds output bursts.
module pdu_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,       // item accepted this cycle
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output pdu_pkg::burst_t burst,
  output logic           burst_push  // item accepted and its burst holds at least one byte
);

  pdu_pkg::phase_t phase, phase_next, phase_step;
  logic [7:0] d1, d2, d3;
  logic [7:0] d1_next, d2_next, d3_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pdu_pkg::PH_IDLE;
      d1    <= 8'h00;
      d2    <= 8'h00;
      d3    <= 8'h00;
    end else if (take) begin
      phase <= phase_next;
      d1    <= d1_next;
      d2    <= d2_next;
      d3    <= d3_next;
    end
  end

  // next state
  always_comb begin
    logic hx;
    logic [7:0] n0;
    hx         = pdu_pkg::is_hex(in_byte);
    n0         = pdu_pkg::pair_value(d1, in_byte);
    d1_next    = d1;
    d2_next    = d2;
    d3_next    = d3;
    phase_step = pdu_pkg::PH_IDLE;
    case (phase)
      pdu_pkg::PH_PCT: begin
        if (hx) begin
          d1_next    = in_byte;
          phase_step = pdu_pkg::PH_PCT_H;
        end else if (in_byte == pdu_pkg::PERCENT) begin
          phase_step = pdu_pkg::PH_PCT;
        end
      end
      pdu_pkg::PH_PCT_H: begin
        if (hx) begin
          d2_next = in_byte;
          if (n0[7]) phase_step = pdu_pkg::PH_PAIR_HI;
        end else if (in_byte == pdu_pkg::PERCENT) begin
          phase_step = pdu_pkg::PH_PCT;
        end
      end
      pdu_pkg::PH_PAIR_HI: begin
        if (in_byte == pdu_pkg::PERCENT) phase_step = pdu_pkg::PH_PAIR_P;
      end
      pdu_pkg::PH_PAIR_P: begin
        if (hx) begin
          d3_next    = in_byte;
          phase_step = pdu_pkg::PH_PAIR_PH;
        end else if (in_byte == pdu_pkg::PERCENT) begin
          phase_step = pdu_pkg::PH_PCT;
        end
      end
      pdu_pkg::PH_PAIR_PH: begin
        if (!hx && in_byte == pdu_pkg::PERCENT) phase_step = pdu_pkg::PH_PCT;
      end
      default: begin
        if (in_byte == pdu_pkg::PERCENT) phase_step = pdu_pkg::PH_PCT;
      end
    endcase
    phase_next = in_last ? pdu_pkg::PH_IDLE : phase_step;
  end

  // outputs: bytes of this item's burst
  always_comb begin
    pdu_pkg::burst_t bu;
    logic hx;
    logic [7:0] n0, n1, pv;
    hx = pdu_pkg::is_hex(in_byte);
    n0 = pdu_pkg::pair_value(d1, d2);
    n1 = pdu_pkg::pair_value(d3, in_byte);
    pv = pdu_pkg::pair_value(d1, in_byte);
    bu = '0;
    case (phase)
      pdu_pkg::PH_PCT: begin
        if (!hx) begin
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
          if (in_byte != pdu_pkg::PERCENT) bu = pdu_pkg::burst_push(bu, in_byte);
        end
      end
      pdu_pkg::PH_PCT_H: begin
        if (hx) begin
          if (!pv[7]) bu = pdu_pkg::burst_push(bu, pv);
        end else begin
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
          bu = pdu_pkg::burst_push(bu, d1);
          if (in_byte != pdu_pkg::PERCENT) bu = pdu_pkg::burst_push(bu, in_byte);
        end
      end
      pdu_pkg::PH_PAIR_HI: begin
        if (in_byte != pdu_pkg::PERCENT) begin
          bu = pdu_pkg::burst_push(bu, n0);
          bu = pdu_pkg::burst_push(bu, in_byte);
        end
      end
      pdu_pkg::PH_PAIR_P: begin
        if (!hx) begin
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
          bu = pdu_pkg::burst_push(bu, d1);
          bu = pdu_pkg::burst_push(bu, d2);
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
          if (in_byte != pdu_pkg::PERCENT) bu = pdu_pkg::burst_push(bu, in_byte);
        end
      end
      pdu_pkg::PH_PAIR_PH: begin
        // two-byte lead 110xxxxx, continuation 10xxxxxx
        if (hx && n0[7:5] == 3'b110 && n1[7:6] == 2'b10) begin
          bu = pdu_pkg::burst_push(bu, {n0[1:0], n1[5:0]});
        end else begin
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
          bu = pdu_pkg::burst_push(bu, d1);
          bu = pdu_pkg::burst_push(bu, d2);
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
          bu = pdu_pkg::burst_push(bu, d3);
          if (in_byte != pdu_pkg::PERCENT) bu = pdu_pkg::burst_push(bu, in_byte);
        end
      end
      default: begin
        if (in_byte != pdu_pkg::PERCENT) bu = pdu_pkg::burst_push(bu, in_byte);
      end
    endcase

    // end of string: flush whatever escape is still open
    if (in_last) begin
      case (phase_step)
        pdu_pkg::PH_PCT: begin
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
        end
        pdu_pkg::PH_PCT_H: begin
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
          bu = pdu_pkg::burst_push(bu, d1_next);
        end
        pdu_pkg::PH_PAIR_HI: begin
          bu = pdu_pkg::burst_push(bu, pdu_pkg::pair_value(d1_next, d2_next));
        end
        pdu_pkg::PH_PAIR_P: begin
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
          bu = pdu_pkg::burst_push(bu, d1_next);
          bu = pdu_pkg::burst_push(bu, d2_next);
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
        end
        pdu_pkg::PH_PAIR_PH: begin
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
          bu = pdu_pkg::burst_push(bu, d1_next);
          bu = pdu_pkg::burst_push(bu, d2_next);
          bu = pdu_pkg::burst_push(bu, pdu_pkg::PERCENT);
          bu = pdu_pkg::burst_push(bu, d3_next);
        end
        default: begin
        end
      endcase
    end
    bu.last    = in_last;
    burst      = bu;
    burst_push = take && (bu.count != '0);
  end

endmodule

### rtl/pdu_queue.sv
// Short queue of bursts between the front and back ends.
module pdu_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pdu_pkg::burst_t push_data,
  input  logic            pop,
  output pdu_pkg::burst_t head,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pdu_pkg::burst_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      fill <= fill + CNT_W'(1);
      else if (pop && !push) fill <= fill - CNT_W'(1);
    end
  end

endmodule

### rtl/pdu_back.sv
// Back end: shifts each burst out one byte per cycle while out_ready is high.
module pdu_back (
  input  logic            clk,
  input  logic            rst,
  input  pdu_pkg::burst_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic [pdu_pkg::BURST_MAX-1:0][7:0] cur_data;
  logic [pdu_pkg::CNT_W-1:0]          cur_left;
  logic                               cur_last;
  logic                               take;

  assign out_valid = (cur_left != '0);
  assign out_byte  = cur_data[0];
  assign out_last  = cur_last && (cur_left == pdu_pkg::CNT_W'(1));
  assign take      = out_valid && out_ready;
  // reload once the current burst is gone or its final byte leaves now
  assign pop       = !empty && (!out_valid || (take && cur_left == pdu_pkg::CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_left <= '0;
    end else if (pop) begin
      cur_left <= head.count;
    end else if (take) begin
      cur_left <= cur_left - pdu_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_data <= head.data;
      cur_last <= head.last;
    end else if (take) begin
      cur_data <= {8'h00, cur_data[pdu_pkg::BURST_MAX-1:1]};
    end
  end

endmodule

### rtl/percent_decode_utf8_to_latin1_top.sv
// Top level of the percent-escape decoder with two-byte UTF-8 folding.
//
//  channel  dir  handshake              tdata                tlast
//  s_axis   in   s_axis_tvalid/tready   [7:0] in_byte        in_last
//  m_axis   out  m_axis_tvalid/tready   [7:0] out_byte       out_last
//
// One input item is taken per cycle while the burst queue has room.
// Each item yields 0 to 6 output items, sent one per cycle by the back end while
// m_axis_tready is high, so the output port sets the rate for malformed escapes.
// A burst is registered in the queue, then loaded into the back end's shift register.
// rst is synchronous and clears the escape phase, the queue and the back end.
// Either side may stall; the queue of QUEUE_DEPTH bursts decouples them.
module percent_decode_utf8_to_latin1_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  pdu_pkg::burst_t burst, head;
  logic            burst_push, full, empty, pop, take;

  assign s_axis_tready = !full;
  assign take          = s_axis_tvalid && !full;

  pdu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .burst      (burst),
    .burst_push (burst_push)
  );

  pdu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (burst_push),
    .push_data (burst),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  pdu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
